// ----- hdl/olpd_pkg.sv -----
// ----------------------------------------------------------------------------
// olpd_pkg - shared types and constants for the ordered list block
// Operation codes, cell commands and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package olpd_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH_DEF   = 16;

    localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
    localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
    localparam logic [1:0] FUNC_ERASE      = 2'd2;
    localparam logic [1:0] FUNC_NONE       = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_ERASE,
        CELL_ROT_FWD,
        CELL_ROT_REV
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  operand;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/olpd_cell.sv -----
// ----------------------------------------------------------------------------
// olpd_cell - one list slot
// Holds one entry and takes a new value from the operand, a neighbor, the head or the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module olpd_cell #(
    parameter int CNT_W = 5,
    parameter int POS   = 0
) (
    input  wire logic                              aclk,
    input  wire olpd_pkg::cell_cmd_t               cmd,
    input  wire logic [CNT_W-1:0]                  count,
    input  wire logic [CNT_W-1:0]                  erase_idx,
    input  wire logic signed [olpd_pkg::DATA_W-1:0] prev_value,
    input  wire logic signed [olpd_pkg::DATA_W-1:0] next_value,
    input  wire logic signed [olpd_pkg::DATA_W-1:0] head_value,
    input  wire logic signed [olpd_pkg::DATA_W-1:0] tail_value,
    output logic signed [olpd_pkg::DATA_W-1:0]      value
);
    import olpd_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);
    localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(POS + 1);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            CELL_PUSH_FRONT: value_next = (MY_POS == '0) ? cmd.operand : prev_value;
            CELL_PUSH_BACK:  if (MY_POS == count) value_next = cmd.operand;
            CELL_ERASE:      if (MY_POS >= erase_idx) value_next = next_value;
            CELL_ROT_FWD: begin
                // slot count-1 wraps around to the head
                if (POS_P1 == count)     value_next = head_value;
                else if (POS_P1 < count) value_next = next_value;
            end
            CELL_ROT_REV: begin
                if (MY_POS == '0)        value_next = tail_value;
                else if (MY_POS < count) value_next = prev_value;
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ----- hdl/ordered_list_push_erase_dump.sv -----
// ----------------------------------------------------------------------------
// ordered_list_push_erase_dump - ordered list with push, erase and dump
// Chain of slots; the dump walks the list by rotating the occupied slots.
// ----------------------------------------------------------------------------
// The first word (forward header) follows the list update through the output register.
// Each item updates the list and then dumps it; a new item is taken only once
//   the last dump word is emitted, one result word per cycle while m_ready is high; code 3 makes no dump.
// The dump rotates the chain once per element, so the list is restored.
// Reset: synchronous, active low; clears count, state and output valid.
// Slot contents are not reset.
`default_nettype none

module ordered_list_push_erase_dump #(
    parameter int DEPTH = olpd_pkg::DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_func,
    input  wire logic signed [olpd_pkg::DATA_W-1:0] s_operand,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_kind,
    output logic                                    m_direction,
    output logic signed [olpd_pkg::DATA_W-1:0]      m_element,
    output logic                                    m_dropped,
    output logic                                    m_last
);
    import olpd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_FWD_HDR = 5'b00010,
        ST_FWD_EL  = 5'b00100,
        ST_REV_HDR = 5'b01000,
        ST_REV_EL  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    walk_reg, walk_next;
    logic                drop_reg, drop_next;

    logic                m_valid_reg;
    logic                m_kind_reg, m_dir_reg, m_drop_reg, m_last_reg;
    logic signed [DATA_W-1:0] m_elem_reg;

    logic                emit_kind, emit_dir, emit_last;
    logic signed [DATA_W-1:0] emit_elem;

    cell_cmd_t           cmd;
    logic [CNT_W-1:0]    erase_idx;
    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] head_value, tail_value;
    logic [IDX_W-1:0]    tail_idx;

    logic in_accept, emit, full, erase_ok, walk_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign emit      = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign erase_ok  = ($unsigned(s_operand) < DATA_W'(count_reg));
    assign erase_idx = s_operand[CNT_W-1:0];
    assign walk_done = ((walk_reg + 1'b1) == count_reg);

    assign tail_idx   = IDX_W'(count_reg - 1'b1);
    assign head_value = cell_value[0];
    assign tail_value = cell_value[tail_idx];

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        drop_next   = drop_reg;
        cmd.op      = CELL_HOLD;
        cmd.operand = s_operand;
        emit_kind   = 1'b0;
        emit_dir    = 1'b0;
        emit_elem   = '0;
        emit_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_func != FUNC_NONE) begin
                    state_next = ST_FWD_HDR;
                    drop_next  = 1'b0;
                    unique case (s_func) inside
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                            if (full) begin
                                drop_next = 1'b1;
                            end else begin
                                cmd.op     = (s_func == FUNC_PUSH_FRONT) ?
                                             CELL_PUSH_FRONT : CELL_PUSH_BACK;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: begin
                            if (erase_ok) begin
                                cmd.op     = CELL_ERASE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_FWD_HDR: begin
                if (emit) begin
                    walk_next  = '0;
                    state_next = (count_reg == '0) ? ST_REV_HDR : ST_FWD_EL;
                end
            end
            ST_FWD_EL: begin
                emit_kind = 1'b1;
                emit_elem = head_value;
                if (emit) begin
                    cmd.op    = CELL_ROT_FWD;
                    walk_next = walk_reg + 1'b1;
                    if (walk_done) state_next = ST_REV_HDR;
                end
            end
            ST_REV_HDR: begin
                emit_dir  = 1'b1;
                emit_last = (count_reg == '0);
                if (emit) begin
                    walk_next  = '0;
                    state_next = (count_reg == '0) ? ST_IDLE : ST_REV_EL;
                end
            end
            ST_REV_EL: begin
                emit_kind = 1'b1;
                emit_dir  = 1'b1;
                emit_elem = tail_value;
                emit_last = walk_done;
                if (emit) begin
                    cmd.op    = CELL_ROT_REV;
                    walk_next = walk_reg + 1'b1;
                    if (walk_done) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        drop_reg <= drop_next;
        if (emit) begin
            m_kind_reg <= emit_kind;
            m_dir_reg  <= emit_dir;
            m_elem_reg <= emit_elem;
            m_drop_reg <= drop_reg;
            m_last_reg <= emit_last;
        end
    end

    // slot chain: each slot sees both neighbors, the head and the tail
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        olpd_cell #(
            .CNT_W (CNT_W),
            .POS   (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .erase_idx  (erase_idx),
            .prev_value (cell_value[(g == 0) ? 0 : g - 1]),
            .next_value (cell_value[(g == DEPTH - 1) ? g : g + 1]),
            .head_value (head_value),
            .tail_value (tail_value),
            .value      (cell_value[g])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_direction = m_dir_reg;
    assign m_element   = m_elem_reg;
    assign m_dropped   = m_drop_reg;
    assign m_last      = m_last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count beyond capacity");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FWD_EL || state_reg == ST_REV_EL) |-> count_reg != '0)
        else $error("element walk on empty list");

    a_header_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_kind_reg) |-> m_elem_reg == '0)
        else $error("header word with nonzero element");

    a_fwd_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_dir_reg) |-> !m_last_reg)
        else $error("last flag on forward dump word");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for ordered_list_push_erase_dump
// Drives push front, push back, erase and no-op words into the list and
// checks every dump word against a shadow copy of the list kept here.
// Directed cases cover empty and full lists and out-of-range erases.
// Random phases mix the two channels' stalls; a separate test holds the output off once for a long time.
// ----------------------------------------------------------------------------
module tb_top;
    import olpd_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic                     kind;
        logic                     direction;
        logic signed [DATA_W-1:0] element;
        logic                     dropped;
        logic                     last;
    } dump_word_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_func    = FUNC_NONE;
    logic signed [DATA_W-1:0] s_operand = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic                     m_kind;
    logic                     m_direction;
    logic signed [DATA_W-1:0] m_element;
    logic                     m_dropped;
    logic                     m_last;

    // shadow list and the dump words it predicts
    logic signed [DATA_W-1:0] shadow_list[$];
    dump_word_t               expected_words[$];
    dump_word_t               head_word;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;
    int  hold_left      = 0;
    int  idle_cycles    = 0;
    bit  growing        = 1'b1;

    int  mismatches     = 0;
    int  ops_sent       = 0;
    int  words_checked  = 0;
    int  drops_seen     = 0;
    int  erase_misses   = 0;
    int  peak_length    = 0;

    ordered_list_push_erase_dump #(.DEPTH(DEPTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_operand   (s_operand),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_direction (m_direction),
        .m_element   (m_element),
        .m_dropped   (m_dropped),
        .m_last      (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        $display("%0t ns  mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Apply one operation to the shadow list and queue the two dumps it causes.
    function automatic void predict_dumps(input logic [1:0] func,
                                          input logic signed [DATA_W-1:0] operand);
        logic        drop;
        logic [31:0] idx;
        dump_word_t  w;
        int          i;
        drop = 1'b0;
        idx  = operand;
        case (func)
            FUNC_PUSH_FRONT: begin
                if (shadow_list.size() >= DEPTH) drop = 1'b1;
                else shadow_list.insert(0, operand);
            end
            FUNC_PUSH_BACK: begin
                if (shadow_list.size() >= DEPTH) drop = 1'b1;
                else shadow_list.insert(shadow_list.size(), operand);
            end
            FUNC_ERASE: begin
                // operand is an unsigned index; negatives never hit
                if (idx < 32'(shadow_list.size())) shadow_list.delete(int'(idx));
                else erase_misses++;
            end
            default: return;
        endcase
        if (drop) drops_seen++;
        if (shadow_list.size() > peak_length) peak_length = shadow_list.size();
        w = '{kind: 1'b0, direction: 1'b0, element: '0, dropped: drop, last: 1'b0};
        expected_words.insert(expected_words.size(), w);
        for (i = 0; i < shadow_list.size(); i++) begin
            w.kind    = 1'b1;
            w.element = shadow_list[i];
            expected_words.insert(expected_words.size(), w);
        end
        w = '{kind: 1'b0, direction: 1'b1, element: '0, dropped: drop, last: 1'b0};
        expected_words.insert(expected_words.size(), w);
        for (i = shadow_list.size() - 1; i >= 0; i--) begin
            w.kind    = 1'b1;
            w.element = shadow_list[i];
            expected_words.insert(expected_words.size(), w);
        end
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Returns at the edge where the word is taken; valid is left high so a
    // following word can go out back to back.
    task automatic send_word(input logic [1:0] func, input logic [31:0] operand);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_operand <= operand;
        do @(posedge aclk); while (!s_ready);
        if (func != FUNC_NONE) ops_sent++;
        predict_dumps(func, operand);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_ops();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(FUNC_ERASE, 32'd0);              // erase on empty list
        send_word(FUNC_NONE, 32'hA5A5_A5A5);       // no-op on empty list
        send_word(FUNC_PUSH_BACK, 32'h7FFF_FFFF);
        send_word(FUNC_PUSH_FRONT, 32'h8000_0000);
        send_word(FUNC_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(FUNC_PUSH_FRONT, 32'h0000_0000);
        send_word(FUNC_PUSH_BACK, 32'h0000_0001);
        send_word(FUNC_ERASE, 32'hFFFF_FFFF);      // negative index, no erase
        send_word(FUNC_ERASE, 32'd5);              // index equal to length
        send_word(FUNC_ERASE, 32'h7FFF_FFFF);
        send_word(FUNC_ERASE, 32'd2);              // middle
        send_word(FUNC_ERASE, 32'd3);              // tail
        send_word(FUNC_ERASE, 32'd0);              // head
        send_word(FUNC_NONE, 32'h5555_5555);
        wait_drained();
    endtask

    task automatic test_full_list();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (k = 0; shadow_list.size() < DEPTH; k++)
            send_word(k[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_value());
        send_word(FUNC_PUSH_FRONT, 32'h1234_5678);  // dropped
        send_word(FUNC_PUSH_BACK, 32'h8765_4321);   // dropped
        send_word(FUNC_ERASE, 32'(DEPTH - 1));
        send_word(FUNC_PUSH_FRONT, pick_value());
        send_word(FUNC_ERASE, 32'(DEPTH));          // out of range while full
        send_word(FUNC_ERASE, 32'd0);
        wait_drained();
    endtask

    // Output held off long enough that the block backs up and stalls s_ready.
    task automatic test_output_hold();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= ~hold_req;
        for (k = 0; k < 10; k++) begin
            if (k % 3 == 2) send_word(FUNC_ERASE, 32'(k % 4));
            else send_word(FUNC_PUSH_BACK, pick_value());
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int n_ops, input int send_pct, input int recv_pct);
        int          done;
        int          r;
        logic [1:0]  func;
        logic [31:0] opnd;
        done           = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (done < n_ops) begin
            // swing between empty and full so both ends see traffic
            if (growing && shadow_list.size() == DEPTH && $urandom_range(2) == 0)
                growing = 1'b0;
            else if (!growing && shadow_list.size() == 0 && $urandom_range(1) == 0)
                growing = 1'b1;
            r = $urandom_range(99);
            if (r < 5) func = FUNC_NONE;
            else if (r < (growing ? 72 : 35))
                func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            else func = FUNC_ERASE;
            if (func == FUNC_ERASE && $urandom_range(7) != 0)
                opnd = 32'($urandom_range(shadow_list.size()));
            else opnd = pick_value();
            send_word(func, opnd);
            if (func != FUNC_NONE) done++;
        end
        wait_drained();
    endtask

    // result side: random stalls, plus a long hold on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing expected", 32'd0, m_element);
            end else begin
                head_word = expected_words.pop_front();
                if (m_kind !== head_word.kind)
                    report_mismatch("kind", head_word.kind, m_kind);
                if (m_direction !== head_word.direction)
                    report_mismatch("direction", head_word.direction, m_direction);
                if (m_element !== head_word.element)
                    report_mismatch("element", head_word.element, m_element);
                if (m_dropped !== head_word.dropped)
                    report_mismatch("dropped", head_word.dropped, m_dropped);
                if (m_last !== head_word.last)
                    report_mismatch("last", head_word.last, m_last);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns  no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_full_list();
        test_output_hold();
        test_random_phase(95, 0, 0);
        test_random_phase(90, 59, 0);
        test_random_phase(90, 0, 59);
        test_random_phase(95, 10, 10);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0)
            report_mismatch("words never seen", expected_words.size(), 32'd0);

        $display("Covered %0d list operations: %0d dropped pushes, %0d erase misses, peak %0d.",
                 ops_sent, drops_seen, erase_misses, peak_length);
        $display("Checked %0d dump words under four stall mixes and one long output hold.",
                 words_checked);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- ordered_list_push_erase_dump.f -----
hdl/olpd_pkg.sv
hdl/olpd_cell.sv
hdl/ordered_list_push_erase_dump.sv
bench/tb_top.sv
